// ===== rtl/rss_pkg.sv =====
// shared types, codes and constants for the randomized set block
package rss_pkg;

  localparam int unsigned DEF_CAPACITY = 1024;
  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned COUNT_OUT_W  = 11;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_SAMPLE = 2'd2,
    ACT_NOP    = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_PRESENT = 3'd1,
    ST_ABSENT  = 3'd2,
    ST_FULL    = 3'd3,
    ST_EMPTY   = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_MOVE_RD,
    S_MOVE_WR,
    S_SAMPLE,
    S_SAMP_RD,
    S_RESP
  } state_e;

  typedef struct packed {
    action_e                    action;
    logic signed [VALUE_W-1:0]  value;
    logic [31:0]                random_word;
  } in_word_t;

  typedef struct packed {
    status_e                    status;
    logic signed [VALUE_W-1:0]  sampled_value;
    logic [COUNT_OUT_W-1:0]     member_count;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic    load;
    logic    scan_clr;
    logic    scan_step;
    logic    rd_last;
    logic    wr_ins;
    logic    wr_move;
    logic    dec;
    logic    mul;
    logic    rd_samp;
    logic    set_st;
    status_e st;
    logic    res_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    action_e action;
    logic    scan_done;
    logic    found;
    logic    full;
    logic    empty;
    logic    pos_lt_last;
    logic    out_busy;
  } sts_t;

endpackage

// ===== rtl/rss_ctrl.sv =====
// sequencing state machine for the randomized set block
module rss_ctrl
  import rss_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output cmd_t cmd_o,
  input  sts_t sts_i
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (sts_i.action)
            ACT_INSERT: state_d = S_SCAN;
            ACT_REMOVE: state_d = S_SCAN;
            ACT_SAMPLE: state_d = S_SAMPLE;
            default:    state_d = S_RESP;
          endcase
        end
      end
      S_SCAN: begin
        if (sts_i.scan_done) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts_i.action == ACT_REMOVE && sts_i.found && sts_i.pos_lt_last) begin
          state_d = S_MOVE_RD;
        end else begin
          state_d = S_RESP;
        end
      end
      S_MOVE_RD: state_d = S_MOVE_WR;
      S_MOVE_WR: state_d = S_RESP;
      S_SAMPLE: begin
        state_d = sts_i.empty ? S_RESP : S_SAMP_RD;
      end
      S_SAMP_RD: state_d = S_RESP;
      S_RESP: begin
        if (!sts_i.out_busy) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o      = '0;
    cmd_o.st   = ST_OK;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load     = 1'b1;
          cmd_o.scan_clr = 1'b1;
        end
      end
      S_SCAN: cmd_o.scan_step = 1'b1;
      S_DECIDE: begin
        if (sts_i.action == ACT_INSERT) begin
          if (sts_i.found) begin
            cmd_o.set_st = 1'b1;
            cmd_o.st     = ST_PRESENT;
          end else if (sts_i.full) begin
            cmd_o.set_st = 1'b1;
            cmd_o.st     = ST_FULL;
          end else begin
            cmd_o.wr_ins = 1'b1;
          end
        end else begin
          if (!sts_i.found) begin
            cmd_o.set_st = 1'b1;
            cmd_o.st     = ST_ABSENT;
          end else if (!sts_i.pos_lt_last) begin
            cmd_o.dec = 1'b1;
          end
        end
      end
      S_MOVE_RD: cmd_o.rd_last = 1'b1;
      S_MOVE_WR: begin
        cmd_o.wr_move = 1'b1;
        cmd_o.dec     = 1'b1;
      end
      S_SAMPLE: begin
        if (sts_i.empty) begin
          cmd_o.set_st = 1'b1;
          cmd_o.st     = ST_EMPTY;
        end else begin
          cmd_o.mul = 1'b1;
        end
      end
      S_SAMP_RD: cmd_o.rd_samp = 1'b1;
      S_RESP: begin
        if (!sts_i.out_busy) cmd_o.res_load = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/rss_dp.sv =====
// datapath: dense value store, member count, scan, sample index and result register
module rss_dp
  import rss_pkg::*;
#(
  parameter int unsigned CAPACITY = DEF_CAPACITY
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_word_t  in_word_i,
  input  cmd_t      cmd_i,
  output sts_t      sts_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = 32 + CW;

  logic [VALUE_W-1:0] mem [CAPACITY];

  action_e            action_q;
  logic [VALUE_W-1:0] value_q;
  logic [31:0]        rnd_q;
  logic [CW-1:0]      count_q;
  logic [CW-1:0]      idx_q;
  logic               rd_vld_q;
  logic [AW-1:0]      rd_idx_q;
  logic [VALUE_W-1:0] rdata_q;
  logic               found_q;
  logic [AW-1:0]      pos_q;
  logic [AW-1:0]      samp_idx_q;
  logic               samp_q;
  status_e            st_q;
  logic               out_valid_q;
  out_word_t          out_q;

  logic               match;
  logic               issue;
  logic               re;
  logic [AW-1:0]      raddr;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [VALUE_W-1:0] wdata;
  logic [CW-1:0]      last;
  logic [PW-1:0]      prod;

  assign last  = count_q - CW'(1);
  assign match = rd_vld_q && (rdata_q == value_q);
  assign issue = cmd_i.scan_step && !found_q && !match && (idx_q < count_q);
  assign prod  = PW'(rnd_q) * PW'(count_q);

  // memory port selection
  always_comb begin
    re    = issue | cmd_i.rd_last | cmd_i.rd_samp;
    raddr = idx_q[AW-1:0];
    if (cmd_i.rd_last) raddr = last[AW-1:0];
    else if (cmd_i.rd_samp) raddr = samp_idx_q;
    we    = cmd_i.wr_ins | cmd_i.wr_move;
    waddr = cmd_i.wr_move ? pos_q : count_q[AW-1:0];
    wdata = cmd_i.wr_move ? rdata_q : value_q;
  end

  // dense value store
  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_q <= mem[raddr];
  end

  // captured word and sample index
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      action_q <= in_word_i.action;
      value_q  <= in_word_i.value;
      rnd_q    <= in_word_i.random_word;
    end
    if (cmd_i.mul) samp_idx_q <= prod[32 +: AW];
    if (issue) rd_idx_q <= idx_q[AW-1:0];
    if (cmd_i.scan_step && !found_q && match) pos_q <= rd_idx_q;
    if (cmd_i.res_load) begin
      out_q.status        <= st_q;
      out_q.sampled_value <= samp_q ? rdata_q : '0;
      out_q.member_count  <= COUNT_OUT_W'(count_q);
    end
  end

  // control state: count, scan progress, status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      idx_q       <= '0;
      rd_vld_q    <= 1'b0;
      found_q     <= 1'b0;
      samp_q      <= 1'b0;
      st_q        <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.wr_ins) count_q <= count_q + CW'(1);
      else if (cmd_i.dec) count_q <= last;
      if (cmd_i.scan_clr) begin
        idx_q    <= '0;
        rd_vld_q <= 1'b0;
        found_q  <= 1'b0;
      end else if (cmd_i.scan_step) begin
        rd_vld_q <= issue;
        if (issue) idx_q <= idx_q + CW'(1);
        if (match) found_q <= 1'b1;
      end
      if (cmd_i.load) begin
        st_q   <= ST_OK;
        samp_q <= 1'b0;
      end else begin
        if (cmd_i.set_st) st_q <= cmd_i.st;
        if (cmd_i.rd_samp) samp_q <= 1'b1;
      end
      if (cmd_i.res_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // status to controller
  always_comb begin
    sts_o.action      = cmd_i.load ? in_word_i.action : action_q;
    sts_o.scan_done   = found_q || (!rd_vld_q && !(idx_q < count_q));
    sts_o.found       = found_q;
    sts_o.full        = (count_q >= CW'(CAPACITY));
    sts_o.empty       = (count_q == '0);
    sts_o.pos_lt_last = (CW'(pos_q) < last);
    sts_o.out_busy    = out_valid_q && !out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// ===== rtl/randomized_set_swap_remove_top.sv =====
// top level of the randomized set with insert, swap remove and sampling
//
//  channel | direction | handshake                  | word
//  in      | input     | in_valid_i / in_ready_o    | in_word_i  (in_word_t)
//  out     | output    | out_valid_o / out_ready_i  | out_word_o (out_word_t)
//
// insert and remove scan the value store linearly through its single registered
// read port, and the scan stops at a match. remove then moves the value from the last
// slot into the freed slot unless the match was already last. sample reads one
// slot, or none on an empty set. an unused action goes straight to the result.
// reset clears the count and control; store contents need no clearing.
// a word is accepted while a finished result still waits on the output; the next
// result then holds the controller until the output register frees.
module randomized_set_swap_remove_top
  import rss_pkg::*;
#(
  parameter int unsigned CAPACITY = DEF_CAPACITY
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  cmd_t cmd;
  sts_t sts;

  // controller
  rss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // datapath
  rss_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

// ===== rtl/rss_checker.sv =====
// port level checks for the randomized set block, with its bind
module rss_checker
  import rss_pkg::*;
#(
  parameter int unsigned CAPACITY = DEF_CAPACITY
) (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_word_t  in_word_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_word_t out_word_o
);

  // a waiting input word holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_word_i))
    else $error("input word changed while waiting");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("output word changed while stalled");

  // member count never exceeds capacity
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(out_word_o.member_count) <= CAPACITY)
    else $error("member count above capacity");

  // empty only with no members
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status == ST_EMPTY |-> out_word_o.member_count == '0)
    else $error("empty reported with members");

  // full only at capacity
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status == ST_FULL
      |-> out_word_o.member_count == COUNT_OUT_W'(CAPACITY))
    else $error("full reported below capacity");

endmodule

bind randomized_set_swap_remove_top rss_checker #(.CAPACITY(CAPACITY)) u_rss_checker (.*);
